/* src/kway_merge_dedup_by_time_core_defines.svh */
// Assertion macros shared by the merge core.
`ifndef KWAY_MERGE_DEDUP_BY_TIME_CORE_DEFINES_SVH
`define KWAY_MERGE_DEDUP_BY_TIME_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define KMD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define KMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/kmd_pkg.sv */
// Types and constants of the k-way merge core.
package kmd_pkg;

   localparam int STAMP_W     = 63;
   localparam int PAY_W       = 64;
   localparam int MAX_RESULTS = 64;
   localparam logic [STAMP_W-1:0] STAMP_MASK = {STAMP_W{1'b1}};
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_END  = 1'b1;
   localparam logic REG_LANE_MASK = 1'b0;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_FULL  = 2'd1,
      ST_ORDER = 2'd2,
      ST_DONE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_ACT, S_SCAN, S_RD, S_PAY, S_DUP, S_DWAIT, S_FIN
   } fsm_type;

   typedef struct packed {
      status_type          status;
      logic [STAMP_W-1:0]  out_stamp;
      logic [PAY_W-1:0]    out_payload;
      logic [2:0]          out_lane;
      logic                last;
   } rsp_type;

endpackage

/* src/kmd_req_if.sv */
// Input channel: push or end-mark words.
interface kmd_req_if;
   import kmd_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [2:0]         lane;
   logic [STAMP_W-1:0] stamp;
   logic [PAY_W-1:0]   payload;
   modport source (output valid, opcode, lane, stamp, payload, input ready);
   modport sink (input valid, opcode, lane, stamp, payload, output ready);
endinterface

/* src/kmd_rsp_if.sv */
// Result channel: merged, dropped and done words.
interface kmd_rsp_if;
   import kmd_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [STAMP_W-1:0] out_stamp;
   logic [PAY_W-1:0]   out_payload;
   logic [2:0]         out_lane;
   logic               last;
   modport source (output valid, status, out_stamp, out_payload, out_lane, last,
                   input ready);
   modport sink (input valid, status, out_stamp, out_payload, out_lane, last,
                 output ready);
endinterface

/* src/kmd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kmd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* src/kmd_csr.sv */
// APB-style register port holding the lane mask.
module kmd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  lane_mask
);
   import kmd_pkg::*;

   logic [7:0] mask_ff;
   logic [7:0] mask_in;

   always_comb begin
      mask_in = mask_ff;
      if (psel && penable && pwrite && paddr == REG_LANE_MASK) begin
         mask_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 8'hFF;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign prdata    = (paddr == REG_LANE_MASK) ? {24'd0, mask_ff} : 32'd0;
   assign pready    = 1'b1;
   assign lane_mask = mask_ff;
endmodule

/* src/kway_merge_dedup_by_time_core.sv */
// Top level of the k-way merge core with duplicate-time removal.
// Words on req_ch either push a (stamp, payload) measurement into a lane
// FIFO or mark a lane ended. Results leave on rsp_ch: merged measurements in
// ascending stamp order, drop reports for full lanes and order errors, and a
// done word once every lane in use has ended and drained. The final word
// caused by one input word carries last; an input may cause none.
// The block takes one input word at a time: the accepting cycle applies the
// push or end mark, and the word is then closed before ready rises again.
// For each emitted measurement, one pass over the lanes finds the minimum
// and a second pass drops every equal head, the winner included, refilling
// each lane head through the single read port of the stamp RAM.
// Results wait in a staging register and an output register, so a stalled
// receiver only holds the sequencer when both are full; nothing is lost.
// Reset clears all lane counters and flags and sets the lane mask to all
// ones; the stamp and payload RAMs need no clearing pass. The user writes
// the lane mask over the csr_ port only while idle; nothing enforces it.
module kway_merge_dedup_by_time_core #(
   parameter int LANES      = 8,
   parameter int LANE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   kmd_req_if.sink     req_ch,
   kmd_rsp_if.source   rsp_ch
);
   import kmd_pkg::*;

   localparam int IW = $clog2(LANES);
   localparam int HW = $clog2(LANE_DEPTH);
   localparam int CW = $clog2(LANE_DEPTH + 1);
   localparam int ENTRIES = LANES * LANE_DEPTH;
   localparam int AW = $clog2(ENTRIES);

   logic [7:0] lane_mask;

   kmd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .lane_mask (lane_mask)
   );

   fsm_type            state_ff, state_in;
   logic [6:0]         n_ff, n_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      best_ff, best_in;
   logic [STAMP_W-1:0] bt_ff, bt_in;
   logic               bhave_ff, bhave_in;
   logic [STAMP_W-1:0] last_ff, last_in;
   logic               any_ff, any_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            pend_ff, pend_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic [CW-1:0]      count_ff [LANES];
   logic [CW-1:0]      count_in [LANES];
   logic [HW-1:0]      head_ff [LANES];
   logic [HW-1:0]      head_in [LANES];
   logic               ended_ff [LANES];
   logic               ended_in [LANES];
   logic [STAMP_W-1:0] hd_ff [LANES];
   logic [STAMP_W-1:0] hd_in [LANES];
   logic [STAMP_W-1:0] tl_ff [LANES];
   logic [STAMP_W-1:0] tl_in [LANES];

   logic               we;
   logic [AW-1:0]      waddr;
   logic               s_re, p_re;
   logic [AW-1:0]      s_raddr, p_raddr;
   logic [STAMP_W-1:0] s_rdata;
   logic [PAY_W-1:0]   p_rdata;

   logic               out_free, stage_ok, stage_req;
   rsp_type            stage_val;
   logic               rdy, have, done;
   logic [IW-1:0]      ln_idx;
   logic               ln_used;

   function automatic logic lane_used(input int i, input logic [7:0] mask);
      return (i < LANES) && (i < 8) && mask[3'(i)];
   endfunction

   function automatic logic [AW-1:0] slot(input logic [IW-1:0] ln,
                                          input logic [HW-1:0] hd,
                                          input int off);
      int s;
      s = int'(hd) + off;
      if (s >= LANE_DEPTH) begin
         s = s - LANE_DEPTH;
      end
      return AW'(int'(ln) * LANE_DEPTH + s);
   endfunction

   function automatic logic [HW-1:0] next_head(input logic [HW-1:0] hd);
      return (int'(hd) == LANE_DEPTH - 1) ? '0 : hd + 1'b1;
   endfunction

   kmd_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (req_ch.stamp),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   kmd_ram #(.WIDTH(PAY_W), .DEPTH(ENTRIES)) u_payload_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (req_ch.payload),
      .re    (p_re),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   assign ln_idx  = IW'(req_ch.lane);
   assign ln_used = lane_used(int'(req_ch.lane), lane_mask);
   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      rdy  = 1'b1;
      have = 1'b0;
      done = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         if (lane_used(i, lane_mask)) begin
            if (count_ff[i] == '0 && !ended_ff[i]) begin
               rdy = 1'b0;
            end
            if (count_ff[i] != '0) begin
               have = 1'b1;
            end
            if (count_ff[i] != '0 || !ended_ff[i]) begin
               done = 1'b0;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      bt_in         = bt_ff;
      bhave_in      = bhave_ff;
      last_in       = last_ff;
      any_in        = any_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      ended_in      = ended_ff;
      hd_in         = hd_ff;
      tl_in         = tl_ff;
      we            = 1'b0;
      waddr         = slot(ln_idx, head_ff[ln_idx], int'(count_ff[ln_idx]));
      s_re          = 1'b0;
      s_raddr       = '0;
      p_re          = 1'b0;
      p_raddr       = slot(best_ff, head_ff[best_ff], 0);
      stage_req     = 1'b0;
      stage_val     = '0;

      out_free = !out_valid_ff || rsp_ch.ready;
      stage_ok = !pend_valid_ff || out_free;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_ACT;
               stage_val.out_stamp   = req_ch.stamp;
               stage_val.out_payload = req_ch.payload;
               stage_val.out_lane    = req_ch.lane;
               if (req_ch.opcode == OP_PUSH) begin
                  if (!ln_used || ended_ff[ln_idx]) begin
                     stage_req        = 1'b1;
                     stage_val.status = ST_ORDER;
                  end else if ((any_ff && req_ch.stamp < last_ff) ||
                               (count_ff[ln_idx] != '0 &&
                                req_ch.stamp < tl_ff[ln_idx])) begin
                     stage_req        = 1'b1;
                     stage_val.status = ST_ORDER;
                  end else if (any_ff && req_ch.stamp == last_ff) begin
                     stage_req = 1'b0;
                  end else if (int'(count_ff[ln_idx]) >= LANE_DEPTH) begin
                     stage_req        = 1'b1;
                     stage_val.status = ST_FULL;
                  end else begin
                     we                = 1'b1;
                     count_in[ln_idx]  = count_ff[ln_idx] + 1'b1;
                     tl_in[ln_idx]     = req_ch.stamp;
                     if (count_ff[ln_idx] == '0) begin
                        hd_in[ln_idx] = req_ch.stamp;
                     end
                  end
               end else if (ln_used) begin
                  ended_in[ln_idx] = 1'b1;
               end
            end
         end
         S_ACT: begin
            idx_in   = '0;
            bhave_in = 1'b0;
            if (rdy && have && int'(n_ff) < MAX_RESULTS) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SCAN: begin
            if (lane_used(int'(idx_ff), lane_mask) && count_ff[idx_ff] != '0 &&
                (!bhave_ff || hd_ff[idx_ff] < bt_ff)) begin
               bt_in    = hd_ff[idx_ff];
               best_in  = idx_ff;
               bhave_in = 1'b1;
            end
            if (int'(idx_ff) == LANES - 1) begin
               state_in = S_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RD: begin
            p_re     = 1'b1;
            state_in = S_PAY;
         end
         S_PAY: begin
            if (stage_ok) begin
               stage_req             = 1'b1;
               stage_val.status      = ST_DATA;
               stage_val.out_stamp   = bt_ff;
               stage_val.out_payload = p_rdata;
               stage_val.out_lane    = 3'(best_ff);
               idx_in                = '0;
               state_in              = S_DUP;
            end
         end
         S_DUP: begin
            // Every head equal to the emitted stamp goes, the winner included.
            if (lane_used(int'(idx_ff), lane_mask) && count_ff[idx_ff] != '0 &&
                hd_ff[idx_ff] == bt_ff) begin
               head_in[idx_ff]  = next_head(head_ff[idx_ff]);
               count_in[idx_ff] = count_ff[idx_ff] - 1'b1;
               if (int'(count_ff[idx_ff]) > 1) begin
                  s_re     = 1'b1;
                  s_raddr  = slot(idx_ff, head_ff[idx_ff], 1);
                  state_in = S_DWAIT;
               end
            end else if (int'(idx_ff) == LANES - 1) begin
               last_in  = bt_ff;
               any_in   = 1'b1;
               state_in = S_ACT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DWAIT: begin
            hd_in[idx_ff] = s_rdata;
            state_in      = S_DUP;
         end
         S_FIN: begin
            if (done && int'(n_ff) < MAX_RESULTS && !bhave_ff) begin
               if (stage_ok) begin
                  stage_req        = 1'b1;
                  stage_val.status = ST_DONE;
                  stage_val.out_stamp   = '0;
                  stage_val.out_payload = '0;
                  stage_val.out_lane    = '0;
                  bhave_in         = 1'b1;
               end
            end else if (!pend_valid_ff) begin
               n_in     = '0;
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               n_in          = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (stage_req) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_in.last  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = stage_val;
         pend_valid_in = 1'b1;
         n_in          = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         n_ff          <= '0;
         idx_ff        <= '0;
         best_ff       <= '0;
         bhave_ff      <= 1'b0;
         last_ff       <= '0;
         any_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            ended_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         n_ff          <= n_in;
         idx_ff        <= idx_in;
         best_ff       <= best_in;
         bhave_ff      <= bhave_in;
         last_ff       <= last_in;
         any_ff        <= any_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         ended_ff      <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      bt_ff   <= bt_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
      hd_ff   <= hd_in;
      tl_ff   <= tl_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.out_stamp   = out_ff.out_stamp & STAMP_MASK;
   assign rsp_ch.out_payload = out_ff.out_payload;
   assign rsp_ch.out_lane    = out_ff.out_lane;
   assign rsp_ch.last        = out_ff.last;

`include "kway_merge_dedup_by_time_core_defines.svh"

   `KMD_ASSERT_ALWAYS(a_idle_no_pend, clock, reset,
      !(state_ff == S_IDLE && pend_valid_ff), "staged word left over in idle")
   `KMD_ASSERT_ALWAYS(a_result_cap, clock, reset,
      int'(n_ff) <= MAX_RESULTS, "result count above cap")
   `KMD_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_ch.valid && req_ch.ready, state_ff == S_ACT, "accepted word not processed")
endmodule

/* tb/sv/tb.sv */
// Testbench for the k-way merge core: directed and random push and end-mark traffic against a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kmd_pkg::*;

   localparam int NLANE = 8;
   localparam int DEPTH = 8;
   localparam longint unsigned CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic               opcode;
      logic [2:0]         lane;
      logic [STAMP_W-1:0] stamp;
      logic [PAY_W-1:0]   payload;
   } word_type;

   // Predicts the merged stream and holds the words still to come.
   class merge_board;
      logic [STAMP_W-1:0] fifo_stamp [NLANE][DEPTH];
      logic [PAY_W-1:0]   fifo_pay [NLANE][DEPTH];
      int unsigned        fill [NLANE];
      int unsigned        head [NLANE];
      bit                 ended [NLANE];
      logic [STAMP_W-1:0] last_time;
      bit                 emitted;
      logic [7:0]         mask;
      rsp_type            pending [$];
      int                 errors;

      function new();
         for (int i = 0; i < NLANE; i++) begin
            fill[i] = 0;
            head[i] = 0;
            ended[i] = 0;
         end
         last_time = '0;
         emitted = 0;
         mask = 8'hff;
         errors = 0;
      endfunction

      function bit used(int ln);
         return mask[ln];
      endfunction

      function logic [STAMP_W-1:0] newest(int ln);
         return fifo_stamp[ln][(head[ln] + fill[ln] - 1) % DEPTH];
      endfunction

      function void drop_head(int ln);
         head[ln] = (head[ln] + 1) % DEPTH;
         fill[ln]--;
      endfunction

      function void put(status_type s, logic [STAMP_W-1:0] t, logic [PAY_W-1:0] p,
                        logic [2:0] ln, ref rsp_type r[$]);
         rsp_type w;
         w.status = s;
         w.out_stamp = t;
         w.out_payload = p;
         w.out_lane = ln;
         w.last = 1'b0;
         r.push_back(w);
      endfunction

      function void note_word(word_type w);
         rsp_type r [$];
         int ln;
         bit rdy, have, done;
         int best;
         logic [STAMP_W-1:0] bt;
         ln = int'(w.lane);
         if (w.opcode == OP_PUSH) begin
            if (!used(ln) || ended[ln])
               put(ST_ORDER, w.stamp, w.payload, w.lane, r);
            else if ((emitted && w.stamp < last_time) ||
                     (fill[ln] > 0 && w.stamp < newest(ln)))
               put(ST_ORDER, w.stamp, w.payload, w.lane, r);
            else if (emitted && w.stamp == last_time) begin
               // An already emitted time vanishes without a word.
            end else if (fill[ln] >= DEPTH)
               put(ST_FULL, w.stamp, w.payload, w.lane, r);
            else begin
               fifo_stamp[ln][(head[ln] + fill[ln]) % DEPTH] = w.stamp;
               fifo_pay[ln][(head[ln] + fill[ln]) % DEPTH] = w.payload;
               fill[ln]++;
            end
         end else if (used(ln))
            ended[ln] = 1;

         while (r.size() < MAX_RESULTS) begin
            rdy = 1;
            have = 0;
            best = 0;
            bt = '0;
            for (int i = 0; i < NLANE; i++) begin
               if (!used(i)) continue;
               if (fill[i] == 0) begin
                  if (!ended[i]) rdy = 0;
                  continue;
               end
               if (!have || fifo_stamp[i][head[i]] < bt) begin
                  have = 1;
                  bt = fifo_stamp[i][head[i]];
                  best = i;
               end
            end
            if (!rdy || !have) break;
            put(ST_DATA, bt, fifo_pay[best][head[best]], best[2:0], r);
            drop_head(best);
            for (int i = 0; i < NLANE; i++)
               if (used(i))
                  while (fill[i] > 0 && fifo_stamp[i][head[i]] == bt) drop_head(i);
            last_time = bt;
            emitted = 1;
         end
         if (r.size() < MAX_RESULTS) begin
            done = 1;
            for (int i = 0; i < NLANE; i++)
               if (used(i) && (fill[i] > 0 || !ended[i])) done = 0;
            if (done) put(ST_DONE, '0, '0, '0, r);
         end
         if (r.size() > 0) r[r.size()-1].last = 1'b1;
         foreach (r[k]) pending.push_back(r[k]);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word %p", got));
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.status != want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.out_stamp != want.out_stamp)
            report($sformatf("stamp %0h, want %0h", got.out_stamp, want.out_stamp));
         if (got.out_payload != want.out_payload)
            report($sformatf("payload %0h, want %0h", got.out_payload, want.out_payload));
         if (got.out_lane != want.out_lane)
            report($sformatf("lane %0d, want %0d", got.out_lane, want.out_lane));
         if (got.last != want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic        csr_paddr = REG_LANE_MASK;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kmd_req_if req_ch ();
   kmd_rsp_if rsp_ch ();

   kway_merge_dedup_by_time_core #(.LANES(NLANE), .LANE_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   merge_board board = new();
   longint unsigned cycles = 0;
   bit rsp_idle_on = 1;
   logic [STAMP_W-1:0] time_base;

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_PUSH;
      req_ch.lane = '0;
      req_ch.stamp = '0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** kway_merge_dedup_by_time_core: FAILED **");
         $finish;
      end
   end

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = status_type'(rsp_ch.status);
         got.out_stamp = rsp_ch.out_stamp;
         got.out_payload = rsp_ch.out_payload;
         got.out_lane = rsp_ch.out_lane;
         got.last = rsp_ch.last;
         board.check_word(got);
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= reset ? 1'b0 : (!rsp_idle_on || $urandom_range(99) >= 31);

   task automatic write_mask(logic [7:0] m);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_paddr <= REG_LANE_MASK;
      csr_pwrite <= 1'b1;
      csr_pwdata <= {24'd0, m};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.mask = m;
   endtask

   task automatic send(word_type w, bit gaps);
      @(negedge clock);
      while (gaps && $urandom_range(99) < 31) @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= w.opcode;
      req_ch.lane <= w.lane;
      req_ch.stamp <= w.stamp;
      req_ch.payload <= w.payload;
      do @(posedge clock); while (!req_ch.ready);
      board.note_word(w);
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic push(int ln, logic [STAMP_W-1:0] t, logic [PAY_W-1:0] p, bit gaps);
      word_type w;
      w.opcode = OP_PUSH;
      w.lane = 3'(ln);
      w.stamp = t;
      w.payload = p;
      send(w, gaps);
   endtask

   task automatic end_lane(int ln, bit gaps);
      word_type w;
      w.opcode = OP_END;
      w.lane = 3'(ln);
      w.stamp = STAMP_W'({$urandom, $urandom});
      w.payload = {$urandom, $urandom};
      send(w, gaps);
   endtask

   // Waits for the predicted words to drain, then lets the sequencer settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // One merge round: per_lane*8 mostly ordered pushes to random lanes, shared times, then end marks.
   task automatic round(logic [7:0] m, int per_lane, bit noisy);
      logic [STAMP_W-1:0] t [NLANE];
      int ln;
      for (int i = 0; i < NLANE; i++) t[i] = time_base + $urandom_range(3);
      for (int k = 0; k < per_lane * 8; k++) begin
         ln = $urandom_range(NLANE - 1);
         if (noisy && $urandom_range(9) == 0)
            push(ln, time_base + $urandom_range(40), {$urandom, $urandom}, 1);
         else begin
            push(ln, t[ln], {$urandom, $urandom}, 1);
            t[ln] += $urandom_range(2);
         end
      end
      for (int i = 0; i < NLANE; i++) end_lane(i, 1);
      if (noisy) end_lane($urandom_range(NLANE - 1), 1);
   endtask

   initial begin
      logic [STAMP_W-1:0] big;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, order error, full lane, duplicates, unused lane.
      write_mask(8'h03);
      push(2, 5, 1, 0);
      push(0, 0, '0, 0);
      push(0, 0, '1, 0);
      for (int k = 0; k < 9; k++) push(1, 10 + k, k, 0);
      push(1, 3, 7, 0);
      push(1, 20, 8, 0);
      end_lane(0, 0);
      push(0, 50, 9, 0);
      push(1, 30, 10, 0);
      end_lane(1, 0);
      end_lane(1, 0);
      end_lane(5, 0);
      drain();
      // A fresh reset state is not available, so the largest stamp goes past last time.
      write_mask(8'h01);
      drain();
      write_mask(8'h80);
      big = STAMP_MASK;
      push(7, big - 1, '1, 0);
      push(7, big, 64'h5555_aaaa_5555_aaaa, 0);
      push(7, big, 64'haaaa_5555_aaaa_5555, 0);
      end_lane(7, 0);
      drain();
      write_mask(8'hff);
      drain();

      // Lanes that ended stay ended, so further traffic mostly reports drops.
      rsp_idle_on = 0;
      time_base = 100;
      round(8'hff, 4, 1);
      rsp_idle_on = 1;
      drain();
      for (int n = 0; n < 240; n++) begin
         case ($urandom_range(2))
            0: push($urandom_range(7), STAMP_W'({$urandom, $urandom}),
                    {$urandom, $urandom}, 1);
            1: push($urandom_range(7), STAMP_MASK - STAMP_W'($urandom_range(3)),
                    {$urandom, $urandom}, 1);
            default: end_lane($urandom_range(7), 1);
         endcase
         if (n == 100) begin
            drain();
            write_mask(8'($urandom_range(255)));
         end
      end
      drain();

      if (board.pending.size() != 0)
         board.report($sformatf("%0d words never arrived", board.pending.size()));
      if (board.errors == 0)
         $display("** kway_merge_dedup_by_time_core: PASSED **");
      else
         $display("** kway_merge_dedup_by_time_core: FAILED **");
      $finish;
   end
endmodule

/* kway_merge_dedup_by_time_core.f */
+incdir+src
src/kmd_pkg.sv
src/kmd_req_if.sv
src/kmd_rsp_if.sv
src/kmd_ram.sv
src/kmd_csr.sv
src/kway_merge_dedup_by_time_core.sv
tb/sv/tb.sv
